FILE: rtl/lkv_pkg.sv
// lkv_pkg: operation codes, port field widths and the write command struct
// shared by the key/value slot table modules. No dependencies.
`default_nettype none

package lkv_pkg;

  // operation codes carried on the func field
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_REMOVE = 2'd3
  } lkv_func_t;

  // fixed port field widths
  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;
  localparam int OCC_W   = 5;

  // write command from the decode logic to the slot store
  typedef struct packed {
    logic ins;  // allocate slot: set valid, write key and value
    logic upd;  // overwrite value of a matched slot
    logic rem;  // clear valid of a matched slot
  } lkv_wr_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_store.sv
// lkv_store: slot valid bits, key and value arrays and the occupancy count.
// Depends on lkv_pkg for the write command struct.
`default_nettype none

module lkv_store
  import lkv_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int KW        = 32,
  parameter int VW        = 32,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lkv_wr_t              wr,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire logic [KW-1:0]        wr_key,
  input  wire logic [VW-1:0]        wr_value,
  input  wire logic [IDX_W-1:0]     rd_idx,
  output logic      [VW-1:0]        rd_value,
  output logic      [NUM_SLOTS-1:0] slot_valid,
  output logic      [KW-1:0]        slot_key [NUM_SLOTS],
  output logic      [CNT_W-1:0]     count
);

  logic [NUM_SLOTS-1:0] valid_r;
  logic [KW-1:0]        key_r   [NUM_SLOTS];
  logic [VW-1:0]        value_r [NUM_SLOTS];
  logic [CNT_W-1:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      if (wr.ins) begin
        valid_r[wr_idx] <= 1'b1;
        count_r         <= count_r + CNT_W'(1);
      end else if (wr.rem) begin
        valid_r[wr_idx] <= 1'b0;
        count_r         <= count_r - CNT_W'(1);
      end
    end
  end

  // payload arrays: no reset, only read while the slot is valid
  always_ff @(posedge clk) begin
    if (wr.ins) begin
      key_r[wr_idx] <= wr_key;
    end
    if (wr.ins || wr.upd) begin
      value_r[wr_idx] <= wr_value;
    end
  end

  assign slot_valid = valid_r;
  assign slot_key   = key_r;
  assign count      = count_r;
  assign rd_value   = value_r[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/lkv_lookup.sv
// lkv_lookup: parallel key compare with lowest-slot priority, and lowest
// free slot search. Purely combinational; depends on lkv_pkg only by style.
`default_nettype none

module lkv_lookup
  import lkv_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int KW        = 32,
  parameter int IDX_W     = 4
) (
  input  wire logic [NUM_SLOTS-1:0] slot_valid,
  input  wire logic [KW-1:0]        slot_key [NUM_SLOTS],
  input  wire logic [KW-1:0]        key,
  output logic                      hit,
  output logic      [IDX_W-1:0]     hit_idx,
  output logic                      has_free,
  output logic      [IDX_W-1:0]     free_idx
);

  logic [NUM_SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_key[i] == key);
    end
  end

  // scan from the top so the lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/leaf_slot_key_value_table.sv
// leaf_slot_key_value_table: top level with input register, operation
// decode and result register. Depends on lkv_pkg, lkv_lookup, lkv_store.
`default_nettype none

// A table of 2*HALF_SLOTS unsorted key/value slots. Insert fills the lowest
// free slot without a duplicate check; find, update and remove act on the
// lowest valid slot with an equal key. An accepted item is held in an input
// register; once the result register is free or drained, the key compare
// over all slots, the free slot priority encode and the table update are
// done in one pass into the result register. One item is taken every cycle,
// back to back, as long as results are drained. A stalled result holds the
// input register; a new item still enters while the result register is
// waiting as long as the input register is free. No clearing pass after
// reset: the valid bits clear at once.
module leaf_slot_key_value_table
  import lkv_pkg::*;
#(
  parameter int HALF_SLOTS  = 8,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [KEY_W-1:0]   in_key,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_ok,
  output logic      [VALUE_W-1:0] out_found_value,
  output logic      [SLOT_W-1:0]  out_slot,
  output logic      [OCC_W-1:0]   out_occupancy,
  output logic                    out_now_full,
  output logic                    out_now_empty
);

  localparam int NUM_SLOTS = 2 * HALF_SLOTS;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int KW        = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int VW        = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
  localparam int SX_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int OX_W      = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  // input register
  logic               in_valid_r;
  lkv_func_t          in_func_r;
  logic [KW-1:0]      in_key_r;
  logic [VW-1:0]      in_value_r;

  // result register
  logic               out_valid_r;
  logic               ok_r;
  logic [VALUE_W-1:0] found_value_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [OCC_W-1:0]   occ_r;
  logic               full_r;
  logic               empty_r;

  logic               fire;
  logic               in_take;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [KW-1:0]        slot_key [NUM_SLOTS];
  logic [VW-1:0]        rd_value;
  logic [CNT_W-1:0]     count;

  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               has_free;
  logic [IDX_W-1:0]   free_idx;

  logic               is_ins;
  logic               ok_nxt;
  lkv_wr_t            wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT_W-1:0]   count_nxt;
  logic [SX_W-1:0]    slot_x;
  logic [OX_W-1:0]    occ_x;
  logic [VALUE_W-1:0] found_value_nxt;

  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r  <= lkv_func_t'(in_func);
      in_key_r   <= in_key[KW-1:0];
      in_value_r <= in_value[VW-1:0];
    end
  end

  lkv_lookup #(
    .NUM_SLOTS (NUM_SLOTS),
    .KW        (KW),
    .IDX_W     (IDX_W)
  ) u_lookup (
    .slot_valid (slot_valid),
    .slot_key   (slot_key),
    .key        (in_key_r),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .has_free   (has_free),
    .free_idx   (free_idx)
  );

  // operation decode
  assign is_ins = (in_func_r == FUNC_INSERT);
  assign ok_nxt = is_ins ? has_free : hit;
  assign wr_idx = is_ins ? free_idx : hit_idx;

  always_comb begin
    wr.ins = fire && is_ins && has_free;
    wr.upd = fire && (in_func_r == FUNC_UPDATE) && hit;
    wr.rem = fire && (in_func_r == FUNC_REMOVE) && hit;
  end

  lkv_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .KW        (KW),
    .VW        (VW),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .wr_key     (in_key_r),
    .wr_value   (in_value_r),
    .rd_idx     (hit_idx),
    .rd_value   (rd_value),
    .slot_valid (slot_valid),
    .slot_key   (slot_key),
    .count      (count)
  );

  // count as it stands after this operation
  always_comb begin
    count_nxt = count;
    if (is_ins && has_free) begin
      count_nxt = count + CNT_W'(1);
    end else if ((in_func_r == FUNC_REMOVE) && hit) begin
      count_nxt = count - CNT_W'(1);
    end
  end

  assign slot_x          = ok_nxt ? SX_W'(wr_idx) : '0;
  assign occ_x           = OX_W'(count_nxt);
  assign found_value_nxt = ((in_func_r == FUNC_FIND) && hit) ? VALUE_W'(rd_value) : '1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r          <= ok_nxt;
      found_value_r <= found_value_nxt;
      slot_r        <= slot_x[SLOT_W-1:0];
      occ_r         <= occ_x[OCC_W-1:0];
      full_r        <= (count_nxt == CNT_W'(NUM_SLOTS));
      empty_r       <= (in_func_r == FUNC_REMOVE) && hit && (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_found_value = found_value_r;
  assign out_slot        = slot_r;
  assign out_occupancy   = occ_r;
  assign out_now_full    = full_r;
  assign out_now_empty   = empty_r;

`ifndef NO_ASSERTIONS
  // occupancy count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid) == int'(count))
    else $error("occupancy count out of step with valid bits");

  // a failed operation reports slot zero and the all-ones value
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_slot == '0) && (out_found_value == '1))
    else $error("failed operation with nonzero slot or value");

  // a remove that takes the last entry leaves every slot invalid; only such a remove reports empty
  a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_func_r == FUNC_REMOVE) && hit && (count == CNT_W'(1)))
      |=> (slot_valid == '0))
    else $error("table not empty after removing the last entry");

  // input stage only stalls while holding an item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
